// ===== design/twe_pkg.sv =====
package twe_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned ID_W     = 32;
  localparam int unsigned TYPE_W   = 16;
  localparam int unsigned COUNT_W  = 6;
  localparam int unsigned STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEL   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHECK = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOCHG   = 2'd3;

  localparam int unsigned ENTRY_W = SLOT_W + ID_W + ID_W + TYPE_W + ID_W;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   id;
    logic [ID_W-1:0]   entity;
    logic [TYPE_W-1:0] etype;
    logic [ID_W-1:0]   task_id;
  } entry_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_WAIT  = 7'b0000100,
    S_DONE  = 7'b0001000,
    S_FIRE  = 7'b0010000,
    S_NEXT  = 7'b0100000,
    S_FINAL = 7'b1000000
  } state_t;

endpackage

// ===== design/twe_ram.sv =====
module twe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/timing_wheel_engine_core.sv =====
// add and delete give one result after one scan of the entry memory
// check: per walked slot one scan of the entry memory per fired
//   timer plus one final scan; the single read port of the entry memory sets the rate
// an unknown kind or a slot or now point out of range answers next cycle, busy stays low
// otherwise one item at a time: busy is high from the transfer until the final result
// reset clears the valid bits and the previous point, not the entry memory; no receiver stall
module timing_wheel_engine_core #(
  parameter int unsigned WHEEL_SLOTS  = 64,
  parameter int unsigned POOL_ENTRIES = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [twe_pkg::KIND_W-1:0]   in_kind,
  input  logic [twe_pkg::SLOT_W-1:0]   in_slot,
  input  logic [twe_pkg::ID_W-1:0]     in_timer_id,
  input  logic [twe_pkg::ID_W-1:0]     in_entity_id,
  input  logic [twe_pkg::TYPE_W-1:0]   in_entity_type,
  input  logic [twe_pkg::ID_W-1:0]     in_task_id,
  input  logic [twe_pkg::SLOT_W-1:0]   in_now_point,
  output logic                         out_valid,
  output logic                         out_is_expiry,
  output logic [twe_pkg::ID_W-1:0]     out_fired_id,
  output logic [twe_pkg::SLOT_W-1:0]   out_fired_slot,
  output logic [twe_pkg::ID_W-1:0]     out_fired_entity,
  output logic [twe_pkg::TYPE_W-1:0]   out_fired_type,
  output logic [twe_pkg::ID_W-1:0]     out_fired_task,
  output logic [twe_pkg::COUNT_W-1:0]  out_fired_count,
  output logic [twe_pkg::STATUS_W-1:0] out_status,
  output logic                         out_last
);
  import twe_pkg::*;

  localparam int unsigned IX_W  = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(POOL_ENTRIES + 1);
  localparam logic [SLOT_W:0] NSLOTS = (SLOT_W+1)'(WHEEL_SLOTS);

  state_t state_r, state_nxt;
  logic [POOL_ENTRIES-1:0] valid_r, valid_nxt;
  logic [SLOT_W-1:0] prev_r, prev_nxt;
  logic [SLOT_W-1:0] cur_r, cur_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  entry_t req_r, req_nxt;
  logic [SLOT_W-1:0] now_r, now_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic [CNT_W-1:0] rd_r, rd_nxt;
  logic rdv_r, rdv_nxt;
  logic found_r, found_nxt;
  logic [IX_W-1:0] best_r, best_nxt;
  entry_t best_e_r, best_e_nxt;
  logic free_ok_r, free_ok_nxt;
  logic [IX_W-1:0] free_r, free_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;

  logic ram_we;
  logic [IX_W-1:0] ram_waddr, ram_raddr;
  entry_t ram_rdata;

  logic ov_r, ov_nxt, oexp_r, oexp_nxt, olast_r, olast_nxt;
  entry_t oe_r, oe_nxt;
  logic [COUNT_W-1:0] ocnt_r, ocnt_nxt;
  logic [STATUS_W-1:0] ost_r, ost_nxt;

  twe_ram #(.WIDTH(ENTRY_W), .DEPTH(1 << IX_W)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(req_r),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign ram_raddr = scan_r[IX_W-1:0];
  assign ram_waddr = free_r;
  assign busy = (state_r != S_IDLE);

  logic hit;
  logic [IX_W-1:0] rix;
  assign rix = rd_r[IX_W-1:0];
  assign hit = rdv_r && valid_r[rix] && (ram_rdata.slot == cur_r);

  always_comb begin
    state_nxt = state_r; valid_nxt = valid_r; prev_nxt = prev_r; cur_nxt = cur_r;
    kind_nxt = kind_r; req_nxt = req_r; now_nxt = now_r; scan_nxt = scan_r;
    rd_nxt = scan_r; rdv_nxt = 1'b0; found_nxt = found_r; best_nxt = best_r;
    best_e_nxt = best_e_r; free_ok_nxt = free_ok_r; free_nxt = free_r; cnt_nxt = cnt_r;
    ov_nxt = 1'b0; oexp_nxt = 1'b0; olast_nxt = 1'b0; oe_nxt = '0;
    ocnt_nxt = '0; ost_nxt = ST_OK; ram_we = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt = in_kind;
          req_nxt = '{slot: in_slot, id: in_timer_id, entity: in_entity_id,
                      etype: in_entity_type, task_id: in_task_id};
          now_nxt = in_now_point;
          cur_nxt = (in_kind == KIND_CHECK) ? prev_r : in_slot;
          cnt_nxt = '0;
          if (in_kind != KIND_ADD && in_kind != KIND_DEL && in_kind != KIND_CHECK) begin
            ov_nxt = 1'b1; olast_nxt = 1'b1; ost_nxt = ST_NOCHG;
          end else if ((in_kind == KIND_CHECK && {1'b0, in_now_point} >= NSLOTS) ||
                       (in_kind != KIND_CHECK && {1'b0, in_slot} >= NSLOTS)) begin
            ov_nxt = 1'b1; olast_nxt = 1'b1; ost_nxt = ST_RANGE;
          end else begin
            state_nxt = S_SCAN; scan_nxt = '0; found_nxt = 1'b0; free_ok_nxt = 1'b0;
          end
        end
      end
      S_SCAN: begin
        rdv_nxt = 1'b1;
        scan_nxt = scan_r + 1'b1;
        if (scan_r == CNT_W'(POOL_ENTRIES - 1)) begin
          state_nxt = S_WAIT;
        end
      end
      default: ;
    endcase
    if (state_r == S_SCAN || state_r == S_WAIT) begin
      if (rdv_r) begin
        if (!valid_r[rix] && !free_ok_nxt) begin
          free_ok_nxt = 1'b1; free_nxt = rix;
        end
        if (hit) begin
          if (kind_r == KIND_CHECK) begin
            if (!found_nxt || ram_rdata.id < best_e_nxt.id) begin
              found_nxt = 1'b1; best_nxt = rix; best_e_nxt = ram_rdata;
            end
          end else if (ram_rdata.id == req_r.id && !found_nxt) begin
            found_nxt = 1'b1; best_nxt = rix;
          end
        end
      end
      if (state_r == S_WAIT && !rdv_r) begin
        state_nxt = S_DONE;
      end
    end
    case (state_r)
      S_DONE: begin
        state_nxt = S_IDLE;
        ov_nxt = 1'b1; olast_nxt = 1'b1;
        if (kind_r == KIND_ADD) begin
          if (found_r) begin
            ost_nxt = ST_NOCHG;
          end else if (!free_ok_r) begin
            ost_nxt = ST_FULL;
          end else begin
            ram_we = 1'b1; valid_nxt[free_r] = 1'b1;
          end
        end else if (kind_r == KIND_DEL) begin
          if (found_r) begin
            valid_nxt[best_r] = 1'b0;
          end else begin
            ost_nxt = ST_NOCHG;
          end
        end else if (found_r) begin
          state_nxt = S_SCAN; ov_nxt = 1'b0; olast_nxt = 1'b0;
          valid_nxt[best_r] = 1'b0; cnt_nxt = cnt_r + 1'b1;
          scan_nxt = '0; found_nxt = 1'b0; free_ok_nxt = 1'b0;
          oexp_nxt = 1'b1; oe_nxt = best_e_r; ov_nxt = 1'b1;
        end else if (cur_r == now_r) begin
          prev_nxt = now_r; ocnt_nxt = cnt_r;
        end else begin
          state_nxt = S_SCAN; ov_nxt = 1'b0; olast_nxt = 1'b0;
          cur_nxt = ({1'b0, cur_r} + 1'b1 >= NSLOTS) ? '0 : cur_r + 1'b1;
          scan_nxt = '0; found_nxt = 1'b0; free_ok_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; valid_r <= '0; prev_r <= '0; ov_r <= 1'b0; rdv_r <= 1'b0;
    end else begin
      state_r <= state_nxt; valid_r <= valid_nxt; prev_r <= prev_nxt;
      ov_r <= ov_nxt; rdv_r <= rdv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt; kind_r <= kind_nxt; req_r <= req_nxt; now_r <= now_nxt;
    scan_r <= scan_nxt; rd_r <= rd_nxt; found_r <= found_nxt; best_r <= best_nxt;
    best_e_r <= best_e_nxt; free_ok_r <= free_ok_nxt; free_r <= free_nxt;
    cnt_r <= cnt_nxt; oexp_r <= oexp_nxt; olast_r <= olast_nxt; oe_r <= oe_nxt;
    ocnt_r <= ocnt_nxt; ost_r <= ost_nxt;
  end

  assign out_valid        = ov_r;
  assign out_is_expiry    = oexp_r;
  assign out_fired_id     = oe_r.id;
  assign out_fired_slot   = oe_r.slot;
  assign out_fired_entity = oe_r.entity;
  assign out_fired_type   = oe_r.etype;
  assign out_fired_task   = oe_r.task_id;
  assign out_fired_count  = ocnt_r;
  assign out_status       = ost_r;
  assign out_last         = olast_r;

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy) else $error("last result while busy");
  a_exp_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_expiry |-> !out_last) else $error("expiry marked last");
  a_prev_hold: assert property (@(posedge clk) disable iff (!rst_n)
    busy && $past(busy) && !(out_valid && out_last) |-> $stable(prev_r))
    else $error("previous point moved mid-item");
endmodule
